[src/klr_pkg.sv]
package klr_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int KEY_BITS_DEF = 48;
  localparam int KEY_W        = 48;
  localparam int HID_W        = 8;
  localparam int PAY_W        = 64;
  localparam int OCC_W        = 9;
  localparam int SCAN_GRP     = 16;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POP    = 2'd2
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [HID_W-1:0]   handler_id;
    logic signed [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [HID_W-1:0]        out_handler;
    logic signed [PAY_W-1:0] out_payload;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_DOWN = 2'd1,
    CMD_UP   = 2'd2,
    CMD_CUT  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      cmp;
  } cell_ctl_t;

endpackage

[src/klr_cell.sv]
module klr_cell #(
  parameter int KEY_BITS = klr_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  klr_pkg::cell_ctl_t         ctl,
  input  logic                       cut,
  input  logic                       live,
  input  logic [KEY_BITS-1:0]        cmp_key,
  input  logic [KEY_BITS-1:0]        prev_key,
  input  logic [klr_pkg::HID_W-1:0] prev_hid,
  input  logic [klr_pkg::PAY_W-1:0] prev_pay,
  input  logic [KEY_BITS-1:0]        next_key,
  input  logic [klr_pkg::HID_W-1:0] next_hid,
  input  logic [klr_pkg::PAY_W-1:0] next_pay,
  output logic [KEY_BITS-1:0]        key,
  output logic [klr_pkg::HID_W-1:0] hid,
  output logic [klr_pkg::PAY_W-1:0] pay,
  output logic                       match
);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      klr_pkg::CMD_HOLD: begin
      end
      klr_pkg::CMD_DOWN: begin
        key <= prev_key;
        hid <= prev_hid;
        pay <= prev_pay;
      end
      klr_pkg::CMD_UP: begin
        key <= next_key;
        hid <= next_hid;
        pay <= next_pay;
      end
      klr_pkg::CMD_CUT: begin
        // close the gap only at and below the removed entry
        if (cut) begin
          key <= next_key;
          hid <= next_hid;
          pay <= next_pay;
        end
      end
    endcase
    if (ctl.cmp) begin
      match <= live && (key == cmp_key);
    end
  end

endmodule

[src/klr_scan.sv]
module klr_scan #(
  parameter int DEPTH = klr_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             load,
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] cut,
  output logic             found
);

  localparam int Grp  = klr_pkg::SCAN_GRP;
  localparam int NGrp = (DEPTH + Grp - 1) / Grp;
  localparam int Pad  = NGrp * Grp;
  localparam int Lg   = $clog2(Grp);
  localparam int LgG  = $clog2(NGrp);

  logic [Pad-1:0]  mpad;
  wire  [Pad-1:0]  pf [0:Lg];
  logic [Pad-1:0]  inpref;
  logic [NGrp-1:0] gany;
  wire  [NGrp-1:0] gpf [0:LgG];
  logic [NGrp-1:0] gexcl;

  assign mpad  = Pad'(match);
  assign pf[0] = mpad;

  // prefix OR inside each group, top of stack at the lowest index
  for (genvar s = 0; s < Lg; s++) begin : g_lvl
    for (genvar b = 0; b < Pad; b++) begin : g_bit
      if ((b % Grp) >= (1 << s)) begin : g_or
        assign pf[s+1][b] = pf[s][b] | pf[s][b-(1<<s)];
      end else begin : g_pass
        assign pf[s+1][b] = pf[s][b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      inpref <= pf[Lg];
      for (int g = 0; g < NGrp; g++) begin
        gany[g] <= pf[Lg][g*Grp + Grp - 1];
      end
    end
  end

  assign gpf[0] = gany;

  for (genvar s = 0; s < LgG; s++) begin : g_glvl
    for (genvar g = 0; g < NGrp; g++) begin : g_gbit
      if (g >= (1 << s)) begin : g_or
        assign gpf[s+1][g] = gpf[s][g] | gpf[s][g-(1<<s)];
      end else begin : g_pass
        assign gpf[s+1][g] = gpf[s][g];
      end
    end
  end

  for (genvar g = 0; g < NGrp; g++) begin : g_excl
    if (g == 0) begin : g_first
      assign gexcl[g] = 1'b0;
    end else begin : g_rest
      assign gexcl[g] = gpf[LgG][g-1];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cut
    assign cut[i] = inpref[i] | gexcl[i / Grp];
  end

  assign found = gpf[LgG][NGrp-1];

endmodule

[src/keyed_lifo_registry_core.sv]
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   klr_pkg::req_t (func, key, handler_id, payload)
// rsp      out  rsp_valid/rsp_stall   klr_pkg::rsp_t (ok, out_handler, out_payload, occupancy)
//
// Push, pop and the unused code finish when taken; remove steps through the
// compare in every cell, grouped prefix scan and shift of the cells.
// One request is in work at a time; the result waits in an output register.
// Reset clears the state, the entry count and the result valid flag; the cells need no clearing pass.
// req_stall is high while a remove is in work, or while a held result is stalled.
module keyed_lifo_registry_core #(
  parameter int DEPTH    = klr_pkg::DEPTH_DEF,
  parameter int KEY_BITS = klr_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  klr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output klr_pkg::rsp_t rsp
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int OccW = klr_pkg::OCC_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t             state;
  logic [CntW-1:0]    count;
  logic [CntW-1:0]    count_next;
  logic               res_valid;
  logic               res_valid_next;
  klr_pkg::rsp_t      res;
  klr_pkg::rsp_t      res_next;

  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  klr_pkg::cell_ctl_t ctl;
  logic [KEY_BITS-1:0] req_key;

  logic [KEY_BITS-1:0]        ckey [DEPTH];
  logic [klr_pkg::HID_W-1:0] chid [DEPTH];
  logic [klr_pkg::PAY_W-1:0] cpay [DEPTH];
  logic [DEPTH-1:0]           live;
  logic [DEPTH-1:0]           match;
  logic [DEPTH-1:0]           cut;
  logic                       found;

  assign out_free  = !res_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CntW'(DEPTH));
  assign empty     = (count == '0);
  assign req_key   = KEY_BITS'(req.key);

  always_comb begin
    ctl.cmd        = klr_pkg::CMD_HOLD;
    ctl.cmp        = 1'b0;
    count_next     = count;
    res_next       = res;
    res_valid_next = res_valid && rsp_stall;
    if (accept) begin
      res_next = '0;
      unique case (req.func)
        klr_pkg::FUNC_PUSH: begin
          if (!full) begin
            ctl.cmd    = klr_pkg::CMD_DOWN;
            count_next = count + CntW'(1);
          end
          res_next.ok    = !full;
          res_valid_next = 1'b1;
        end
        klr_pkg::FUNC_REMOVE: begin
          ctl.cmp = 1'b1;
        end
        klr_pkg::FUNC_POP: begin
          if (!empty) begin
            ctl.cmd                = klr_pkg::CMD_UP;
            count_next             = count - CntW'(1);
            res_next.out_handler   = chid[0];
            res_next.out_payload   = cpay[0];
          end
          res_next.ok    = !empty;
          res_valid_next = 1'b1;
        end
        default: begin
          res_valid_next = 1'b1;
        end
      endcase
      res_next.occupancy = OccW'(count_next);
    end
    // hold the scan result until the output register frees up
    if (state == S_SHIFT && out_free) begin
      ctl.cmd = klr_pkg::CMD_CUT;
      if (found) begin
        count_next = count - CntW'(1);
      end
      res_next.ok        = found;
      res_next.occupancy = OccW'(count_next);
      res_valid_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count     <= count_next;
      res_valid <= res_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accept && req.func == klr_pkg::FUNC_REMOVE) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid = res_valid;
  assign rsp       = res;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]        pkey;
    logic [klr_pkg::HID_W-1:0] phid;
    logic [klr_pkg::PAY_W-1:0] ppay;
    logic [KEY_BITS-1:0]        nkey;
    logic [klr_pkg::HID_W-1:0] nhid;
    logic [klr_pkg::PAY_W-1:0] npay;

    if (i == 0) begin : g_head
      assign pkey = req_key;
      assign phid = req.handler_id;
      assign ppay = req.payload;
    end else begin : g_body
      assign pkey = ckey[i-1];
      assign phid = chid[i-1];
      assign ppay = cpay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nkey = ckey[i];
      assign nhid = chid[i];
      assign npay = cpay[i];
    end else begin : g_link
      assign nkey = ckey[i+1];
      assign nhid = chid[i+1];
      assign npay = cpay[i+1];
    end

    assign live[i] = (CntW'(i) < count);

    klr_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cut     (cut[i]),
      .live    (live[i]),
      .cmp_key (req_key),
      .prev_key(pkey),
      .prev_hid(phid),
      .prev_pay(ppay),
      .next_key(nkey),
      .next_hid(nhid),
      .next_pay(npay),
      .key     (ckey[i]),
      .hid     (chid[i]),
      .pay     (cpay[i]),
      .match   (match[i])
    );
  end

  klr_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .clk  (clk),
    .load (state == S_SCAN),
    .match(match),
    .cut  (cut),
    .found(found)
  );

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SHIFT))
    else $error("scan not followed by shift");

  assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken while remove in work");

  assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == klr_pkg::FUNC_POP && !empty)
      |=> (count == $past(count) - CntW'(1)) && rsp_valid && rsp.ok)
    else $error("pop of a live entry did not release it");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> $stable(count) && !rsp_valid)
    else $error("count changed during remove scan");

endmodule
